@@ rtl/smooth_vertex_normal_accumulator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the smooth vertex normal accumulator
// Shared property templates, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SMOOTH_VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH
`define SMOOTH_VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define SVNA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVNA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/svna_pkg.sv @@
// ----------------------------------------------------------------------------
// svna_pkg
// Types, constants and helpers shared by the vertex normal accumulator.
// ----------------------------------------------------------------------------
package svna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int ACCUM_BITS   = 24;
  localparam int ADDR_W       = $clog2(VERTEX_COUNT);
  localparam int IDX_W        = 10;
  localparam int POS_W        = 16;
  localparam int NRM_W        = 16;
  localparam int EDGE_W       = POS_W + 1;
  localparam int VEC_W        = 36;
  localparam int ONE_Q14      = 16384;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_A,
    ST_POS_B,
    ST_POS_C,
    ST_EDGE,
    ST_CROSS,
    ST_UNIT,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_WAIT,
    ST_ACC_RD,
    ST_ACC_WB,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SHIFT,
    U_SQ,
    U_SQRT,
    U_DIV_INIT,
    U_DIV,
    U_DONE
  } ustate_t;

  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic nonzero;
  } unit_rsp_t;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

  // Saturating accumulate of a Q1.14 term into an accumulator.
  function automatic logic signed [ACCUM_BITS-1:0] sat_add(
    input logic signed [ACCUM_BITS-1:0] a,
    input logic signed [NRM_W-1:0]      b
  );
    logic signed [ACCUM_BITS:0] s;
    s = (ACCUM_BITS+1)'(a) + (ACCUM_BITS+1)'(b);
    if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
      return s[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                           : {1'b0, {(ACCUM_BITS-1){1'b1}}};
    end
    return s[ACCUM_BITS-1:0];
  endfunction

endpackage

@@ rtl/svna_ram.sv @@
// ----------------------------------------------------------------------------
// svna_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module svna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/svna_unit.sv @@
// ----------------------------------------------------------------------------
// svna_unit
// Scales a signed 3-vector to a Q1.14 unit vector: bit-serial normalize,
// sum of squares, square root and division.
// ----------------------------------------------------------------------------
module svna_unit
  import svna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  unit_req_t               req,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic signed [VEC_W-1:0] vec_z,
  output unit_rsp_t               rsp,
  output logic signed [NRM_W-1:0] n_x,
  output logic signed [NRM_W-1:0] n_y,
  output logic signed [NRM_W-1:0] n_z
);

  localparam int SUM_W  = 50;
  localparam int ROOT_W = 25;
  localparam int REM_W  = 28;
  localparam int DIV_W  = 39;
  localparam int DSR_W  = DIV_W + 1;
  localparam int QUO_W  = 16;

  ustate_t                 state_r, state_nxt;
  logic [VEC_W-1:0]        mag_r [3];
  logic                    neg_r [3];
  logic [SUM_W-1:0]        sum_r;
  logic [REM_W-1:0]        rem_r;
  logic [ROOT_W-1:0]       root_r;
  logic [4:0]              cnt_r;
  logic [1:0]              comp_r;
  logic [DIV_W-1:0]        drem_r;
  logic [DSR_W-1:0]        dsr_r;
  logic [QUO_W-1:0]        quo_r;
  logic signed [NRM_W-1:0] n_r [3];
  logic                    nonzero_r;

  logic             all_zero, too_big, too_small;
  logic [23:0]      mag_sel;
  logic [REM_W-1:0] sq_trial_rem, sq_trial;
  logic             sq_take, div_take;
  logic [QUO_W-1:0] quo_fin, q_clamp;

  always_comb begin
    all_zero  = (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
    too_big   = (|mag_r[0][VEC_W-1:24]) || (|mag_r[1][VEC_W-1:24]) ||
                (|mag_r[2][VEC_W-1:24]);
    too_small = !((|mag_r[0][VEC_W-1:23]) || (|mag_r[1][VEC_W-1:23]) ||
                  (|mag_r[2][VEC_W-1:23]));
    mag_sel   = mag_r[comp_r][23:0];
    sq_trial_rem = {rem_r[REM_W-3:0], sum_r[SUM_W-1:SUM_W-2]};
    sq_trial     = REM_W'({root_r, 2'b01});
    sq_take      = sq_trial_rem >= sq_trial;
    div_take     = {1'b0, drem_r} >= dsr_r;
    quo_fin      = {quo_r[QUO_W-2:0], div_take};
    q_clamp      = (quo_fin > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : quo_fin;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      U_IDLE:     if (req.start) state_nxt = all_zero ? U_DONE : U_SHIFT;
      U_SHIFT:    if (!too_big && !too_small) state_nxt = U_SQ;
      U_SQ:       if (comp_r == 2'd2) state_nxt = U_SQRT;
      U_SQRT:     if (cnt_r == 5'(ROOT_W - 1)) state_nxt = U_DIV_INIT;
      U_DIV_INIT: state_nxt = U_DIV;
      U_DIV: begin
        if (cnt_r == 5'(QUO_W - 1)) state_nxt = (comp_r == 2'd2) ? U_DONE : U_DIV_INIT;
      end
      U_DONE:     state_nxt = U_IDLE;
      default:    state_nxt = U_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done    = (state_r == U_DONE);
    rsp.nonzero = nonzero_r;
    n_x         = n_r[0];
    n_y         = n_r[1];
    n_z         = n_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        mag_r[0]  <= vec_x[VEC_W-1] ? VEC_W'(-vec_x) : vec_x;
        mag_r[1]  <= vec_y[VEC_W-1] ? VEC_W'(-vec_y) : vec_y;
        mag_r[2]  <= vec_z[VEC_W-1] ? VEC_W'(-vec_z) : vec_z;
        neg_r[0]  <= vec_x[VEC_W-1];
        neg_r[1]  <= vec_y[VEC_W-1];
        neg_r[2]  <= vec_z[VEC_W-1];
        nonzero_r <= !all_zero;
      end
      U_SHIFT: begin
        // Truncating right shifts one bit at a time match a single wide shift.
        for (int i = 0; i < 3; i++) begin
          if (too_big) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else if (too_small) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
        comp_r <= 2'd0;
        sum_r  <= '0;
      end
      U_SQ: begin
        sum_r  <= sum_r + SUM_W'(mag_sel * mag_sel);
        comp_r <= comp_r + 2'd1;
        cnt_r  <= '0;
        rem_r  <= '0;
        root_r <= '0;
      end
      U_SQRT: begin
        rem_r  <= sq_take ? (sq_trial_rem - sq_trial) : sq_trial_rem;
        root_r <= {root_r[ROOT_W-2:0], sq_take};
        sum_r  <= sum_r << 2;
        cnt_r  <= cnt_r + 5'd1;
        comp_r <= 2'd0;
      end
      U_DIV_INIT: begin
        drem_r <= DIV_W'({mag_sel, 14'd0}) + DIV_W'(root_r >> 1);
        dsr_r  <= DSR_W'(root_r) << (QUO_W - 1);
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      U_DIV: begin
        if (div_take) begin
          drem_r <= drem_r - DIV_W'(dsr_r);
        end
        dsr_r <= dsr_r >> 1;
        quo_r <= quo_fin;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(QUO_W - 1)) begin
          n_r[comp_r] <= neg_r[comp_r] ? NRM_W'(-$signed(q_clamp)) : $signed(q_clamp);
          comp_r      <= comp_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/smooth_vertex_normal_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator_top
// Vertex store with per-vertex normal accumulation and unit-normal readout.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load writes both RAMs as it is
// accepted. A triangle reads its three positions from the position RAM,
// forms the cross product with one multiplier, normalizes it and then does
// a read-modify-write of each corner's accumulators. A read fetches one
// accumulator entry, normalizes it and hands the result to the output
// register. Normalization sets the cost: up to about 24 shift steps, 3 square
// steps, a 25-step bit-serial square root and a 16-step divider per component.
// Degenerate triangles skip the accumulator update. An out-of-range read
// returns zero with zero_sum set; an out-of-range load or triangle is dropped.
// A finished read waits in the output register while the next transaction is
// accepted.
`include "smooth_vertex_normal_accumulator_top_defines.svh"

module smooth_vertex_normal_accumulator_top
  import svna_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertex_index, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
  // init_nx, init_ny, init_nz
  input  logic [135:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_nx, out_ny, out_nz
  output logic [47:0]  out_tdata,
  // zero_sum
  output logic         out_tuser
);

  localparam int POS_ROW = 3 * POS_W;
  localparam int ACC_ROW = 3 * ACCUM_BITS;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] vi_r, a_r, b_r, c_r;
  logic [1:0]       corner_r;
  logic [2:0]       step_r;
  logic             tri_r, ok_r;
  logic signed [POS_W-1:0]  pa_r [3];
  logic signed [POS_W-1:0]  pb_r [3];
  logic signed [EDGE_W-1:0] e0_r [3];
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [VEC_W-1:0]  cr_r [3];
  logic                     out_valid_r;
  logic [47:0]              out_data_r;
  logic                     out_zero_r;

  logic [IDX_W-1:0]        in_vi, in_a, in_b, in_c;
  logic signed [POS_W-1:0] in_px, in_py, in_pz;
  logic signed [NRM_W-1:0] in_nx, in_ny, in_nz;
  logic                    fire, out_free;

  logic               pos_we, acc_we;
  logic [ADDR_W-1:0]  pos_raddr, acc_waddr, acc_raddr;
  logic [POS_ROW-1:0] pos_wdata, pos_rdata;
  logic [ACC_ROW-1:0] acc_wdata, acc_rdata;
  logic [IDX_W-1:0]   corner_idx;

  logic signed [POS_W-1:0]      pc [3];
  logic signed [ACCUM_BITS-1:0] acc_v [3];
  logic signed [EDGE_W-1:0]     mul_a, mul_b;
  logic                         mul_sub;
  logic signed [2*EDGE_W-1:0]   prod;

  unit_req_t               ureq;
  unit_rsp_t               ursp;
  logic signed [VEC_W-1:0] uvec [3];
  logic signed [NRM_W-1:0] un [3];

  assign in_vi = in_tdata[9:0];
  assign in_a  = in_tdata[19:10];
  assign in_b  = in_tdata[29:20];
  assign in_c  = in_tdata[39:30];
  assign in_px = in_tdata[55:40];
  assign in_py = in_tdata[71:56];
  assign in_pz = in_tdata[87:72];
  assign in_nx = in_tdata[103:88];
  assign in_ny = in_tdata[119:104];
  assign in_nz = in_tdata[135:120];

  assign in_tready  = (state_r == ST_IDLE);
  assign fire       = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  always_comb begin
    case (corner_r)
      2'd0:    corner_idx = a_r;
      2'd1:    corner_idx = b_r;
      default: corner_idx = c_r;
    endcase
    for (int i = 0; i < 3; i++) begin
      pc[i]    = pos_rdata[i*POS_W +: POS_W];
      acc_v[i] = acc_rdata[i*ACCUM_BITS +: ACCUM_BITS];
    end
  end

  // Cross product terms, one product per cycle.
  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = e0_r[1]; mul_b = e1_r[2]; mul_sub = 1'b0; end
      3'd1:    begin mul_a = e0_r[2]; mul_b = e1_r[1]; mul_sub = 1'b1; end
      3'd2:    begin mul_a = e0_r[2]; mul_b = e1_r[0]; mul_sub = 1'b0; end
      3'd3:    begin mul_a = e0_r[0]; mul_b = e1_r[2]; mul_sub = 1'b1; end
      3'd4:    begin mul_a = e0_r[0]; mul_b = e1_r[1]; mul_sub = 1'b0; end
      default: begin mul_a = e0_r[1]; mul_b = e1_r[0]; mul_sub = 1'b1; end
    endcase
    prod = mul_a * mul_b;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          case (cmd_t'(in_tuser))
            CMD_TRI: begin
              if (in_range(in_a) && in_range(in_b) && in_range(in_c)) state_nxt = ST_POS_A;
            end
            CMD_READ: state_nxt = in_range(in_vi) ? ST_RD_ADDR : ST_OUT;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POS_A:   state_nxt = ST_POS_B;
      ST_POS_B:   state_nxt = ST_POS_C;
      ST_POS_C:   state_nxt = ST_EDGE;
      ST_EDGE:    state_nxt = ST_CROSS;
      ST_CROSS:   if (step_r == 3'd5) state_nxt = ST_UNIT;
      ST_UNIT:    state_nxt = ST_WAIT;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (ursp.done) begin
          if (!tri_r) state_nxt = ST_OUT;
          else        state_nxt = ursp.nonzero ? ST_ACC_RD : ST_IDLE;
        end
      end
      ST_ACC_RD:  state_nxt = ST_ACC_WB;
      ST_ACC_WB:  state_nxt = (corner_r == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_OUT:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Memory and unit controls.
  always_comb begin
    pos_we    = fire && (cmd_t'(in_tuser) == CMD_LOAD) && in_range(in_vi);
    pos_wdata = {in_pz, in_py, in_px};
    case (state_r)
      ST_POS_A: pos_raddr = to_addr(a_r);
      ST_POS_B: pos_raddr = to_addr(b_r);
      default:  pos_raddr = to_addr(c_r);
    endcase

    acc_we    = pos_we || (state_r == ST_ACC_WB);
    acc_raddr = (state_r == ST_ACC_RD) ? to_addr(corner_idx) : to_addr(vi_r);
    if (state_r == ST_ACC_WB) begin
      acc_waddr = to_addr(corner_idx);
      acc_wdata = {sat_add(acc_v[2], un[2]), sat_add(acc_v[1], un[1]),
                   sat_add(acc_v[0], un[0])};
    end else begin
      acc_waddr = to_addr(in_vi);
      acc_wdata = {ACCUM_BITS'(in_nz), ACCUM_BITS'(in_ny), ACCUM_BITS'(in_nx)};
    end

    ureq.start = (state_r == ST_UNIT) || (state_r == ST_RD_DATA);
    for (int i = 0; i < 3; i++) begin
      uvec[i] = (state_r == ST_RD_DATA) ? VEC_W'(acc_v[i]) : cr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      vi_r  <= in_vi;
      a_r   <= in_a;
      b_r   <= in_b;
      c_r   <= in_c;
      tri_r <= (cmd_t'(in_tuser) == CMD_TRI);
      ok_r  <= 1'b0;
    end
    if (state_r == ST_POS_B) pa_r <= pc;
    if (state_r == ST_POS_C) pb_r <= pc;
    if (state_r == ST_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= EDGE_W'(pb_r[i]) - EDGE_W'(pa_r[i]);
        e1_r[i] <= EDGE_W'(pc[i]) - EDGE_W'(pa_r[i]);
        cr_r[i] <= '0;
      end
      step_r <= '0;
    end
    if (state_r == ST_CROSS) begin
      cr_r[step_r[2:1]] <= mul_sub ? cr_r[step_r[2:1]] - VEC_W'(prod)
                                   : cr_r[step_r[2:1]] + VEC_W'(prod);
      step_r <= step_r + 3'd1;
    end
    if (state_r == ST_WAIT && ursp.done) begin
      ok_r     <= ursp.nonzero;
      corner_r <= 2'd0;
    end
    if (state_r == ST_ACC_WB) corner_r <= corner_r + 2'd1;
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= ok_r ? {un[2], un[1], un[0]} : '0;
      out_zero_r <= !ok_r;
    end
  end

  svna_ram #(.WIDTH(POS_ROW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (to_addr(in_vi)),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  svna_ram #(.WIDTH(ACC_ROW), .DEPTH(VERTEX_COUNT)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  svna_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .vec_x (uvec[0]),
    .vec_y (uvec[1]),
    .vec_z (uvec[2]),
    .rsp   (ursp),
    .n_x   (un[0]),
    .n_y   (un[1]),
    .n_z   (un[2])
  );

  `SVNA_ASSERT_NOW(a_zero_flag_data, out_valid_r && out_zero_r, out_data_r == '0, "zero flag with nonzero data")
  `SVNA_ASSERT_NOW(a_acc_write_state, acc_we, state_r == ST_IDLE || state_r == ST_ACC_WB, "accumulator write outside idle or write-back")
  `SVNA_ASSERT_NOW(a_unit_done_wait, ursp.done, state_r == ST_WAIT, "normalizer finished while not awaited")
  `SVNA_ASSERT_NEXT(a_out_load, state_r == ST_OUT && out_free, out_valid_r && state_r == ST_IDLE, "read result not registered")

endmodule
